[hdl/pcbp_pkg.sv]
package pcbp_pkg;

	localparam int MAXD = 6;
	localparam int CW   = 32;
	localparam int RW   = 31;

	localparam logic [1:0] KIND_CORNER = 2'd0;
	localparam logic [1:0] KIND_AFTER  = 2'd1;
	localparam logic [1:0] KIND_BEFORE = 2'd2;

	typedef logic [MAXD-1:0][CW-1:0] coords_t;

	typedef struct packed {
		coords_t       cur;
		coords_t       prev;
		logic [RW-1:0] cur_r;
		logic [RW-1:0] prev_r;
		logic          last;
		logic          first;
	} job_t;

endpackage

[hdl/polyline_corner_blend_points_top.sv]
// A first corner goes from the idle state straight to the emit state; a later corner gives
// its last point after leaving the queue and passing through, in order, the
// bit-serial square root (35 steps), a 6-step reciprocal third and the shared one-bit-a-cycle
// divider (64 steps, run per coordinate and blend; skipped when the corner repeats).
// A two-entry queue takes new corners while the back end works on an earlier one.
// Reset: arst_n clears the stored corner, the queue and the output valid flag.
module polyline_corner_blend_points_top import pcbp_pkg::*; #(
	parameter int NUM_DIMS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] coord_0,
	input  logic [31:0] coord_1,
	input  logic [31:0] coord_2,
	input  logic [31:0] coord_3,
	input  logic [31:0] coord_4,
	input  logic [31:0] coord_5,
	input  logic [31:0] corner_radius,
	input  logic        is_last_corner,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_0,
	output logic [31:0] out_1,
	output logic [31:0] out_2,
	output logic [31:0] out_3,
	output logic [31:0] out_4,
	output logic [31:0] out_5,
	output logic [1:0]  point_kind,
	output logic        final_point,
	output logic        status
);

	coords_t coord;
	coords_t out_c;
	job_t    wjob;
	job_t    rjob;
	logic    push;
	logic    pop;
	logic    full;
	logic    empty;

	assign coord = {coord_5, coord_4, coord_3, coord_2, coord_1, coord_0};

	pcbp_front #(.NUM_DIMS(NUM_DIMS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.coord          (coord),
		.corner_radius  (corner_radius),
		.is_last_corner (is_last_corner),
		.full           (full),
		.push           (push),
		.job            (wjob)
	);

	pcbp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wjob),
		.pop    (pop),
		.rdata  (rjob),
		.full   (full),
		.empty  (empty)
	);

	pcbp_back #(.NUM_DIMS(NUM_DIMS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (rjob),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_c       (out_c),
		.point_kind  (point_kind),
		.final_point (final_point),
		.status      (status)
	);

	assign out_0 = out_c[0];
	assign out_1 = out_c[1];
	assign out_2 = out_c[2];
	assign out_3 = out_c[3];
	assign out_4 = out_c[4];
	assign out_5 = out_c[5];

endmodule

[hdl/pcbp_front.sv]
module pcbp_front import pcbp_pkg::*; #(
	parameter int NUM_DIMS = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  coords_t       coord,
	input  logic [CW-1:0] corner_radius,
	input  logic          is_last_corner,
	input  logic          full,
	output logic          push,
	output job_t          job
);

	coords_t       prev_q;
	logic [RW-1:0] prev_r_q;
	logic          have_q;
	coords_t       cur;
	logic [RW-1:0] rad;

	always_comb begin
		for (int k = 0; k < MAXD; k++) begin
			cur[k] = (k < NUM_DIMS) ? coord[k] : '0;
		end
	end

	// negative radius clamps to zero
	assign rad      = corner_radius[CW-1] ? '0 : corner_radius[RW-1:0];
	assign in_ready = !full;
	assign push     = in_valid && !full;

	assign job.cur    = cur;
	assign job.prev   = prev_q;
	assign job.cur_r  = rad;
	assign job.prev_r = prev_r_q;
	assign job.last   = is_last_corner;
	assign job.first  = !have_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			prev_r_q <= '0;
			have_q   <= 1'b0;
		end else if (push) begin
			have_q <= !is_last_corner;
			if (!is_last_corner) begin
				prev_q   <= cur;
				prev_r_q <= rad;
			end
		end
	end

endmodule

[hdl/pcbp_fifo.sv]
module pcbp_fifo import pcbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	input  logic pop,
	output job_t rdata,
	output logic full,
	output logic empty
);

	job_t       mem [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[hdl/pcbp_back.sv]
module pcbp_back import pcbp_pkg::*; #(
	parameter int NUM_DIMS = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  job_t          job,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output coords_t       out_c,
	output logic [1:0]    point_kind,
	output logic          final_point,
	output logic          status
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQ   = 4'd1;
	localparam logic [3:0] S_SQRT = 4'd2;
	localparam logic [3:0] S_DIV3 = 4'd3;
	localparam logic [3:0] S_MAG  = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_NEXT = 4'd7;
	localparam logic [3:0] S_EMIT = 4'd8;

	localparam logic [1:0] EK_FIRST  = 2'd0;
	localparam logic [1:0] EK_AFTER  = 2'd1;
	localparam logic [1:0] EK_BEFORE = 2'd2;
	localparam logic [1:0] EK_CORNER = 2'd3;

	localparam logic [2:0] K_LAST = 3'(NUM_DIMS - 1);

	logic [3:0]    st_q;
	logic          ov_q;
	job_t          job_q;
	logic [2:0]    k_q;
	logic          b_q;
	logic [1:0]    ek_q;
	logic [66:0]   acc_q;
	logic [69:0]   rad_q;
	logic [37:0]   rem_q;
	logic [34:0]   root_q;
	logic [63:0]   dn_q;
	logic [35:0]   dr_q;
	logic [34:0]   dd_q;
	logic [5:0]    cnt_q;
	logic [RW-1:0] len0_q;
	logic [RW-1:0] len1_q;
	logic [32:0]   mag_q;
	logic          neg_q;
	coords_t       res_q;
	coords_t       oc_q;
	logic [1:0]    okind_q;
	logic          ofin_q;
	logic          ost_q;

	logic [32:0]   d;
	logic [32:0]   mag;
	logic [65:0]   sq;
	logic [66:0]   acc_nx;
	logic [37:0]   rem_sh;
	logic [37:0]   trial;
	logic          sge;
	logic [34:0]   root_nx;
	logic [35:0]   dr_sh;
	logic          dge;
	logic [63:0]   dn_nx;
	logic [35:0]   dr_nx;
	logic [RW-1:0] lenm;
	logic [63:0]   prod;
	logic [RW-1:0] qv;
	logic [CW-1:0] base;
	logic          can_emit;
	logic          emit_go;
	logic [69:0]   p3;
	logic [33:0]   third;

	assign d      = {job_q.cur[k_q][CW-1], job_q.cur[k_q]}
	              - {job_q.prev[k_q][CW-1], job_q.prev[k_q]};
	assign mag    = d[32] ? (~d + 33'd1) : d;
	assign sq     = mag * mag;
	assign acc_nx = acc_q + {1'b0, sq};

	assign rem_sh  = {rem_q[35:0], rad_q[69:68]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign sge     = (rem_sh >= trial);
	assign root_nx = {root_q[33:0], sge};

	assign dr_sh = {dr_q[34:0], dn_q[63]};
	assign dge   = (dr_sh >= {1'b0, dd_q});
	assign dn_nx = {dn_q[62:0], dge};
	assign dr_nx = dge ? (dr_sh - {1'b0, dd_q}) : dr_sh;

	// root / 3 as root * (2^35 + 1) / 3 >> 35, the product built up in rad_q
	assign p3    = {rad_q[68:0], 1'b0} + {35'd0, root_q};
	assign third = p3[68:35];

	assign lenm = b_q ? len1_q : len0_q;
	assign prod = mag_q * lenm;
	assign qv   = (root_q == '0) ? '0 : dn_q[RW-1:0];
	assign base = b_q ? job_q.cur[k_q] : job_q.prev[k_q];

	assign can_emit = !ov_q || out_ready;
	assign emit_go  = (st_q == S_EMIT) && can_emit;
	assign pop      = (st_q == S_IDLE) && !empty;

	assign out_valid   = ov_q;
	assign out_c       = oc_q;
	assign point_kind  = okind_q;
	assign final_point = ofin_q;
	assign status      = ost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && out_ready && !emit_go) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (!empty) begin
						st_q <= job.first ? S_EMIT : S_SQ;
					end
				end
				S_SQ: begin
					if (k_q == K_LAST) begin
						st_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (cnt_q == '0) begin
						st_q <= S_DIV3;
					end
				end
				S_DIV3: begin
					if (cnt_q == '0) begin
						st_q <= S_MAG;
					end
				end
				S_MAG: st_q <= S_MUL;
				S_MUL: st_q <= (root_q == '0) ? S_NEXT : S_DIV;
				S_DIV: begin
					if (cnt_q == '0) begin
						st_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (k_q == K_LAST) begin
						st_q <= S_EMIT;
					end else begin
						st_q <= S_MAG;
					end
				end
				S_EMIT: begin
					if (can_emit) begin
						ov_q <= 1'b1;
						if (ek_q == EK_FIRST || ek_q == EK_CORNER) begin
							st_q <= S_IDLE;
						end else if (ek_q == EK_AFTER) begin
							st_q <= S_MAG;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				job_q <= job;
				res_q <= '0;
				acc_q <= '0;
				k_q   <= '0;
				b_q   <= 1'b0;
				ek_q  <= EK_FIRST;
			end
			S_SQ: begin
				acc_q <= acc_nx;
				k_q   <= k_q + 3'd1;
				if (k_q == K_LAST) begin
					rad_q  <= {3'b000, acc_nx};
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= 6'd34;
				end
			end
			S_SQRT: begin
				rem_q  <= sge ? (rem_sh - trial) : rem_sh;
				root_q <= root_nx;
				if (cnt_q == '0) begin
					rad_q <= {35'd0, root_nx};
					cnt_q <= 6'd5;
				end else begin
					rad_q <= {rad_q[67:0], 2'b00};
					cnt_q <= cnt_q - 6'd1;
				end
			end
			S_DIV3: begin
				if (cnt_q == '0) begin
					len0_q <= ({3'd0, job_q.prev_r} < third) ? job_q.prev_r : third[RW-1:0];
					len1_q <= ({3'd0, job_q.cur_r} < third) ? job_q.cur_r : third[RW-1:0];
					k_q    <= '0;
				end else begin
					cnt_q <= cnt_q - 6'd1;
					case (cnt_q)
						6'd5:    rad_q <= rad_q + {rad_q[67:0], 2'b00};
						6'd4:    rad_q <= rad_q + {rad_q[65:0], 4'h0};
						6'd3:    rad_q <= rad_q + {rad_q[61:0], 8'h00};
						6'd2:    rad_q <= rad_q + {rad_q[53:0], 16'h0000};
						default: rad_q <= rad_q + {3'd0, root_q, 32'd0};
					endcase
				end
			end
			S_MAG: begin
				mag_q <= mag;
				neg_q <= b_q ? (!d[32] && (d != '0)) : d[32];
			end
			S_MUL: begin
				dn_q  <= prod + {30'd0, root_q[34:1]};
				dd_q  <= root_q;
				dr_q  <= '0;
				cnt_q <= 6'd63;
			end
			S_DIV: begin
				dn_q  <= dn_nx;
				dr_q  <= dr_nx;
				cnt_q <= cnt_q - 6'd1;
			end
			S_NEXT: begin
				res_q[k_q] <= neg_q ? (base - {1'b0, qv}) : (base + {1'b0, qv});
				k_q        <= k_q + 3'd1;
				if (k_q == K_LAST) begin
					ek_q <= b_q ? EK_BEFORE : EK_AFTER;
				end
			end
			S_EMIT: begin
				if (can_emit) begin
					case (ek_q)
						EK_AFTER: begin
							oc_q    <= res_q;
							okind_q <= KIND_AFTER;
							ofin_q  <= 1'b0;
							ost_q   <= 1'b0;
							b_q     <= 1'b1;
							k_q     <= '0;
						end
						EK_BEFORE: begin
							oc_q    <= res_q;
							okind_q <= KIND_BEFORE;
							ofin_q  <= 1'b0;
							ost_q   <= 1'b0;
							ek_q    <= EK_CORNER;
						end
						EK_CORNER: begin
							oc_q    <= job_q.cur;
							okind_q <= KIND_CORNER;
							ofin_q  <= job_q.last;
							ost_q   <= 1'b0;
						end
						default: begin
							oc_q    <= job_q.cur;
							okind_q <= KIND_CORNER;
							ofin_q  <= job_q.last;
							ost_q   <= job_q.last;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

[dv/polyline_corner_blend_points_top_tb.sv]
`timescale 1ns / 100ps

module polyline_corner_blend_points_top_tb;
	import pcbp_pkg::*;

	localparam int NDIM = 6;

	typedef struct {
		logic [CW-1:0] c [MAXD];
		logic [1:0]    kind;
		logic          fin;
		logic          st;
	} ctrl_point_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] coord [MAXD];
	logic [31:0] corner_radius;
	logic        is_last_corner;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] out_c [MAXD];
	logic [1:0]  point_kind;
	logic        final_point;
	logic        status;

	ctrl_point_t pending_points [$];
	longint      held_corner [MAXD];
	longint      held_radius;
	bit          corner_held;
	int          mismatches;
	bit          rx_quiet;
	int          rx_holdoff;
	int          idle_pct;

	polyline_corner_blend_points_top #(.NUM_DIMS(NDIM)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.coord_0(coord[0]), .coord_1(coord[1]), .coord_2(coord[2]),
		.coord_3(coord[3]), .coord_4(coord[4]), .coord_5(coord[5]),
		.corner_radius(corner_radius), .is_last_corner(is_last_corner),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_0(out_c[0]), .out_1(out_c[1]), .out_2(out_c[2]),
		.out_3(out_c[3]), .out_4(out_c[4]), .out_5(out_c[5]),
		.point_kind(point_kind), .final_point(final_point), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("polyline_corner_blend_points_top test failed");
		$finish;
	end

	function automatic logic [67:0] root_floor(logic [67:0] s);
		logic [71:0] r;
		logic [71:0] t;
		r = '0;
		for (int b = 34; b >= 0; b--) begin
			t = r | (72'd1 << b);
			if (t * t <= {4'd0, s})
				r = t;
		end
		return r[67:0];
	endfunction

	function automatic void blend_toward(input longint base [MAXD],
			input longint tow [MAXD], input longint rad, output longint res [MAXD]);
		longint      d [MAXD];
		logic [67:0] sum;
		logic [67:0] m;
		logic [67:0] n;
		logic [67:0] len;
		logic [67:0] q;
		sum = '0;
		for (int i = 0; i < MAXD; i++) begin
			d[i] = (i < NDIM) ? tow[i] - base[i] : 0;
			m = (d[i] < 0) ? -d[i] : d[i];
			sum += m * m;
		end
		n = root_floor(sum);
		len = n / 3;
		if (rad < len)
			len = rad;
		for (int i = 0; i < MAXD; i++) begin
			q = 0;
			if (n != 0) begin
				m = (d[i] < 0) ? -d[i] : d[i];
				q = (m * len + n / 2) / n;
			end
			res[i] = (i < NDIM) ? base[i] + ((d[i] < 0) ? -longint'(q) : longint'(q)) : 0;
		end
	endfunction

	function automatic ctrl_point_t make_point(longint p [MAXD], logic [1:0] k,
			logic f, logic s);
		ctrl_point_t cp;
		for (int i = 0; i < MAXD; i++)
			cp.c[i] = (i < NDIM) ? p[i][31:0] : '0;
		cp.kind = k;
		cp.fin = f;
		cp.st = s;
		return cp;
	endfunction

	task automatic predict_points(logic [31:0] cin [MAXD], logic [31:0] rin, logic last);
		longint cur [MAXD];
		longint a [MAXD];
		longint b [MAXD];
		longint r;
		for (int i = 0; i < MAXD; i++)
			cur[i] = (i < NDIM) ? longint'($signed(cin[i])) : 0;
		r = longint'($signed(rin));
		if (r < 0)
			r = 0;
		if (!corner_held) begin
			pending_points = {pending_points, make_point(cur, KIND_CORNER, last, last)};
		end else begin
			blend_toward(held_corner, cur, held_radius, a);
			blend_toward(cur, held_corner, r, b);
			pending_points = {pending_points, make_point(a, KIND_AFTER, 1'b0, 1'b0)};
			pending_points = {pending_points, make_point(b, KIND_BEFORE, 1'b0, 1'b0)};
			pending_points = {pending_points, make_point(cur, KIND_CORNER, last, 1'b0)};
		end
		corner_held = !last;
		held_corner = cur;
		held_radius = r;
	endtask

	task automatic send_corner(logic [31:0] cin [MAXD], logic [31:0] rin, logic last);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct)
			@(negedge clk);
		coord = cin;
		corner_radius = rin;
		is_last_corner = last;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_points(cin, rin, last);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_simple(int x, int r, logic last);
		logic [31:0] c [MAXD];
		for (int i = 0; i < MAXD; i++)
			c[i] = 32'(x * (i + 1));
		send_corner(c, 32'(r), last);
	endtask

	task automatic drain;
		while (pending_points.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(4000)) - 32'd2000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(logic last);
		logic [31:0] c [MAXD];
		logic [31:0] r;
		for (int i = 0; i < MAXD; i++)
			c[i] = rand_coord();
		r = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(32'h00ff_ffff));
		send_corner(c, r, last);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction kind %0d", point_kind);
			end else begin
				ctrl_point_t e;
				bit bad;
				e = pending_points.pop_front();
				bad = (point_kind !== e.kind) || (final_point !== e.fin)
					|| (status !== e.st);
				for (int i = 0; i < MAXD; i++)
					if (out_c[i] !== e.c[i])
						bad = 1'b1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp %h %h %h %h %h %h k%0d f%0d s%0d",
							e.c[0], e.c[1], e.c[2], e.c[3], e.c[4], e.c[5],
							e.kind, e.fin, e.st);
						$display("          got %h %h %h %h %h %h k%0d f%0d s%0d",
							out_c[0], out_c[1], out_c[2], out_c[3], out_c[4], out_c[5],
							point_kind, final_point, status);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (rx_holdoff > 0) begin
			rx_holdoff <= rx_holdoff - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= rx_quiet || idle_pct == 0 || $urandom_range(99) >= idle_pct;
		end
	end

	task automatic test_lone_and_basic;
		send_simple(5 << 16, 1 << 16, 1'b1);
		send_simple(0, 0, 1'b0);
		send_simple(9 << 16, 1 << 16, 1'b0);
		send_simple(9 << 16, 2 << 16, 1'b0);
		send_simple(-3 << 16, -5, 1'b0);
		send_simple(1, 32'h7fff_ffff, 1'b1);
		drain();
	endtask

	task automatic test_extremes;
		logic [31:0] hi [MAXD];
		logic [31:0] lo [MAXD];
		for (int i = 0; i < MAXD; i++) begin
			hi[i] = 32'h7fff_ffff;
			lo[i] = 32'h8000_0000;
		end
		send_corner(hi, 32'h7fff_ffff, 1'b0);
		send_corner(lo, 32'h7fff_ffff, 1'b0);
		send_corner(hi, 32'h8000_0000, 1'b0);
		send_corner(hi, 32'hffff_ffff, 1'b1);
		send_corner(lo, 32'h0000_0000, 1'b1);
		send_simple(0, 32'h0001_0000, 1'b0);
		send_simple(3, 32'h7fff_ffff, 1'b0);
		send_simple(-3, 32'h7fff_ffff, 1'b1);
		drain();
	endtask

	task automatic test_backpressure;
		rx_holdoff = 3000;
		for (int i = 0; i < 8; i++)
			send_random(i == 7);
		drain();
	endtask

	task automatic test_random_polylines;
		int sent;
		int len;
		sent = 0;
		while (sent < 156) begin
			rx_quiet = (sent > 60 && sent < 100);
			idle_pct = rx_quiet ? 0 : 6;
			len = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 2);
			for (int k = 0; k < len; k++)
				send_random(k == len - 1);
			sent += len;
		end
		rx_quiet = 1'b0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		for (int i = 0; i < MAXD; i++)
			coord[i] = '0;
		corner_radius = '0;
		is_last_corner = 1'b0;
		out_ready = 1'b0;
		mismatches = 0;
		corner_held = 1'b0;
		held_radius = 0;
		for (int i = 0; i < MAXD; i++)
			held_corner[i] = 0;
		rx_quiet = 1'b0;
		rx_holdoff = 0;
		idle_pct = 6;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_lone_and_basic();
		test_extremes();
		test_backpressure();
		test_random_polylines();
		if (mismatches == 0 && pending_points.size() == 0)
			$display("polyline_corner_blend_points_top test passed");
		else
			$display("polyline_corner_blend_points_top test failed");
		$finish;
	end

endmodule

[polyline_corner_blend_points_top.f]
hdl/pcbp_pkg.sv
hdl/pcbp_front.sv
hdl/pcbp_fifo.sv
hdl/pcbp_back.sv
hdl/polyline_corner_blend_points_top.sv
dv/polyline_corner_blend_points_top_tb.sv
